/* rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Field widths fixed by the word formats
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int CURSOR_W = 11;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    OP_PUT_CUR = 2'd0,
    OP_PUT_AT  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } tcw_op_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_DONE
  } tcw_state_t;

endpackage

/* rtl/text_console_writer_unit.sv */
// Text console writer top level: command decode, cursor and buffer sequencer.
//
//  Channel  Direction  Handshake               Payload
//  in_      slave      in_tvalid / in_tready   tuser opcode, tdata char/column/row
//  out_     master     out_tvalid / out_tready tdata cursor/scrolled/char/attr/error
//  cfg_     write only cfg_wr_en               cfg_wr_data text attribute
//
//  Put (cursor or position): at most one buffer write in the exec cycle.
//  Read cell: the exec state issues the registered read of the cell RAM and the read state takes its data.
//  Scroll and clear: the RAM is walked one cell a cycle.
//  After reset a zeroing pass over all COLUMNS*ROWS cells runs with in_tready low.
//  A result waits in the output register while out_tready is low; the next word
//  is taken meanwhile and its own result stalls in a hold state until the slot frees.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // tuser: [1:0] opcode
  // tdata: [7:0] char_code, [14:8] column, [19:15] row_index, [23:20] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [23:0] in_tdata,
  // tdata: [10:0] cursor_cell, [11] scrolled, [19:12] read_char,
  //        [27:20] read_attr, [28] position_error, [31:29] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  // Flat cell index from row and column
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(int'(r) * COLUMNS + int'(c));
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  tcw_state_t          state_r, state_nxt;
  logic [AW-1:0]       w_r, w_nxt;          // walk pointer for fill and shift
  logic                init_r, init_nxt;    // fill is the post-reset zeroing pass
  logic [CELL_W-1:0]   fill_r, fill_nxt;
  logic [ATTR_W-1:0]   attr_r;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;

  // Latched command word
  tcw_op_t             op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [COL_IN_W-1:0] col_in_r;
  logic [ROW_IN_W-1:0] row_in_r;

  // Pending result
  logic                res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0]   res_rch_r, res_rch_nxt;
  logic [ATTR_W-1:0]   res_rattr_r, res_rattr_nxt;
  logic                res_err_r, res_err_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [CURSOR_W-1:0] out_cursor_r;
  logic                out_scr_r;
  logic [CHAR_W-1:0]   out_rch_r;
  logic [ATTR_W-1:0]   out_rattr_r;
  logic                out_err_r;

  // RAM ports
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic                accept, finish, load;
  logic [ATTR_W-1:0]   eff_attr;
  logic                pos_bad;
  logic [RW-1:0]       base_row;
  logic [CW-1:0]       base_col;
  logic [AW:0]         rd_next;

  assign eff_attr  = (attr_r == '0) ? DEFAULT_ATTR : attr_r;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign pos_bad   = (int'(col_in_r) >= COLUMNS) || (int'(row_in_r) >= ROWS);
  assign base_row  = (op_r == OP_PUT_AT) ? RW'(row_in_r) : cur_row_r;
  assign base_col  = (op_r == OP_PUT_AT) ? CW'(col_in_r) : cur_col_r;
  assign rd_next   = (AW+1)'(w_r) + (AW+1)'(COLUMNS + 1);

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    init_nxt      = init_r;
    fill_nxt      = fill_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    res_scr_nxt   = res_scr_r;
    res_rch_nxt   = res_rch_r;
    res_rattr_nxt = res_rattr_r;
    res_err_nxt   = res_err_r;
    finish        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = w_r;
        mem_wdata = fill_r;
        if (w_r == AW'(CELLS - 1)) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_scr_nxt   = 1'b0;
        res_rch_nxt   = '0;
        res_rattr_nxt = '0;
        res_err_nxt   = 1'b0;
        unique case (op_r)
          OP_CLEAR: begin
            fill_nxt    = {eff_attr, CH_SPACE};
            w_nxt       = '0;
            init_nxt    = 1'b0;
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            state_nxt   = S_FILL;
          end
          OP_READ: begin
            if (pos_bad) begin
              res_err_nxt = 1'b1;
              finish      = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(RW'(row_in_r), CW'(col_in_r));
              state_nxt = S_READ;
            end
          end
          OP_PUT_CUR, OP_PUT_AT: begin
            if ((op_r == OP_PUT_AT) && pos_bad) begin
              res_err_nxt = 1'b1;
              finish      = 1'b1;
            end else begin
              if (ch_r == CH_NEWLINE) begin
                cur_col_nxt = '0;
                if (int'(base_row) + 1 == ROWS) begin
                  // blank would fall below the screen: suppressed, scroll only
                  res_scr_nxt = 1'b1;
                  cur_row_nxt = RW'(ROWS - 1);
                end else begin
                  cur_row_nxt = base_row + RW'(1);
                  mem_we      = 1'b1;
                  mem_waddr   = cell_addr(base_row + RW'(1), '0);
                  mem_wdata   = {eff_attr, CH_SPACE};
                end
              end else if (ch_r == CH_BACKSPACE) begin
                if (base_col != '0) begin
                  cur_col_nxt = base_col - CW'(1);
                  cur_row_nxt = base_row;
                end else if (base_row != '0) begin
                  cur_col_nxt = CW'(COLUMNS - 1);
                  cur_row_nxt = base_row - RW'(1);
                end else begin
                  // saturates at cell zero
                  cur_col_nxt = '0;
                  cur_row_nxt = '0;
                end
                mem_we    = 1'b1;
                mem_waddr = cell_addr(cur_row_nxt, cur_col_nxt);
                mem_wdata = {eff_attr, CH_SPACE};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(base_row, base_col);
                mem_wdata = {eff_attr, ch_r};
                if (int'(base_col) + 1 == COLUMNS) begin
                  cur_col_nxt = '0;
                  if (int'(base_row) + 1 == ROWS) begin
                    res_scr_nxt = 1'b1;
                    cur_row_nxt = RW'(ROWS - 1);
                  end else begin
                    cur_row_nxt = base_row + RW'(1);
                  end
                end else begin
                  cur_col_nxt = base_col + CW'(1);
                  cur_row_nxt = base_row;
                end
              end
              if (res_scr_nxt) begin
                // prefetch the first source cell of the shift
                mem_re    = 1'b1;
                mem_raddr = AW'(COLUMNS);
                w_nxt     = '0;
                state_nxt = S_SHIFT;
              end else begin
                finish = 1'b1;
              end
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      S_READ: begin
        res_rch_nxt   = mem_rdata[CHAR_W-1:0];
        res_rattr_nxt = mem_rdata[CELL_W-1:CHAR_W];
        finish        = 1'b1;
      end

      S_SHIFT: begin
        // cell w takes cell w+COLUMNS read last cycle; last row is zeroed
        mem_we    = 1'b1;
        mem_waddr = w_r;
        mem_wdata = (int'(w_r) >= CELLS - COLUMNS) ? '0 : mem_rdata;
        if (int'(rd_next) < CELLS) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_next);
        end
        if (w_r == AW'(CELLS - 1)) begin
          finish = 1'b1;
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end

      S_DONE: begin
        finish = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result hand-off to the output register, or hold until the slot frees
    load = 1'b0;
    if (finish) begin
      if (!out_valid_r || out_tready) begin
        load      = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_DONE;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      w_r         <= '0;
      init_r      <= 1'b1;
      fill_r      <= '0;
      attr_r      <= DEFAULT_ATTR;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      init_r      <= init_nxt;
      fill_r      <= fill_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= tcw_op_t'(in_tuser);
      ch_r     <= in_tdata[7:0];
      col_in_r <= in_tdata[14:8];
      row_in_r <= in_tdata[19:15];
    end
    res_scr_r   <= res_scr_nxt;
    res_rch_r   <= res_rch_nxt;
    res_rattr_r <= res_rattr_nxt;
    res_err_r   <= res_err_nxt;
    if (load) begin
      out_cursor_r <= CURSOR_W'(int'(cur_row_nxt) * COLUMNS + int'(cur_col_nxt));
      out_scr_r    <= res_scr_nxt;
      out_rch_r    <= res_rch_nxt;
      out_rattr_r  <= res_rattr_nxt;
      out_err_r    <= res_err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_err_r, out_rattr_r, out_rch_r, out_scr_r, out_cursor_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < CELLS))
    else $error("cell write beyond the buffer");

  a_shift_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((int'(cur_row_r) == ROWS - 1) && (cur_col_r == '0)))
    else $error("scroll running with cursor off the last row start");

  a_scroll_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> !out_err_r)
    else $error("scroll reported together with a position error");

endmodule

/* rtl/tcw_cell_ram.sv */
// Cell buffer: simple dual-port RAM, one write and one registered read port.
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* test/tb_text_console_writer_unit.sv */
// Self-checking testbench for the text console writer: directed table, then random phases.
module tb_text_console_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int PHASE_WORDS = 425;     // four random phases, about 1700 words
  localparam int CYCLE_LIMIT = 4000000; // clear/scroll walks cover every cell
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTS  = 40;

  // one result word, field by field
  typedef struct {
    logic [10:0] cursor;
    logic        scrolled;
    logic [7:0]  rd_char;
    logic [7:0]  rd_attr;
    logic        pos_err;
  } console_result_t;

  // one command word; fixed_res is used in place of the prediction when has_fixed is set
  typedef struct {
    tcw_op_t         op;
    logic [7:0]      ch;
    logic [6:0]      col;
    logic [4:0]      row;
    bit              has_fixed;
    console_result_t fixed_res;
  } console_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the console: screen, cursor and the text attribute register
  logic [15:0] screen_shadow [CELLS];
  int          cursor_shadow;
  logic [7:0]  attr_shadow;

  console_result_t pending_results[$];  // predicted results still owed by the block
  console_cmd_t    directed_cmds[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;
  int tx_idle_pct   = 0;  // chance in 100 that the sender holds back a cycle
  int rx_stall_pct  = 0;  // chance in 100 that the receiver drops tready

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    out_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // Result checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[10:0] !== want.cursor)
          report_mismatch("cursor_cell", out_tdata[10:0], want.cursor);
        if (out_tdata[11] !== want.scrolled)
          report_mismatch("scrolled", out_tdata[11], want.scrolled);
        if (out_tdata[19:12] !== want.rd_char)
          report_mismatch("read_char", out_tdata[19:12], want.rd_char);
        if (out_tdata[27:20] !== want.rd_attr)
          report_mismatch("read_attr", out_tdata[27:20], want.rd_attr);
        if (out_tdata[28] !== want.pos_err)
          report_mismatch("position_error", out_tdata[28], want.pos_err);
      end
      results_seen++;
    end
  end

  // Console behaviour: applies one command to the shadow state, returns the result word
  function automatic console_result_t predict_console(tcw_op_t op, logic [7:0] ch,
                                                      logic [6:0] col, logic [4:0] row);
    console_result_t r;
    logic [7:0]      eff_attr;
    bit              off_screen;
    int              p;
    eff_attr   = (attr_shadow == 8'd0) ? DEFAULT_ATTR : attr_shadow;
    off_screen = (int'(col) >= COLUMNS) || (int'(row) >= ROWS);
    r.scrolled = 1'b0;
    r.rd_char  = 8'd0;
    r.rd_attr  = 8'd0;
    r.pos_err  = 1'b0;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++)
        screen_shadow[i] = {eff_attr, CH_SPACE};
      cursor_shadow = 0;
    end else if (op != OP_PUT_CUR && off_screen) begin
      // bad position: nothing moves
      r.pos_err = 1'b1;
    end else if (op == OP_READ) begin
      {r.rd_attr, r.rd_char} = screen_shadow[int'(row) * COLUMNS + int'(col)];
    end else begin
      p = (op == OP_PUT_AT) ? int'(row) * COLUMNS + int'(col) : cursor_shadow;
      if (ch == CH_NEWLINE) begin
        p = (p / COLUMNS + 1) * COLUMNS;
        if (p < CELLS)
          screen_shadow[p] = {eff_attr, CH_SPACE};  // no blank below the last row
      end else if (ch == CH_BACKSPACE) begin
        if (p > 0)
          p--;
        screen_shadow[p] = {eff_attr, CH_SPACE};
      end else begin
        screen_shadow[p] = {eff_attr, ch};
        p++;
      end
      if (p >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++)
          screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
          screen_shadow[i] = 16'd0;
        r.scrolled = 1'b1;
        p -= COLUMNS;
      end
      cursor_shadow = p;
    end
    r.cursor = cursor_shadow[10:0];
    return r;
  endfunction

  // Adds one row to the directed table
  task automatic plan_word(tcw_op_t op, logic [7:0] ch, logic [6:0] col, logic [4:0] row,
                           bit has_fixed = 1'b0, int cur = 0, bit scr = 1'b0,
                           logic [7:0] rc = 8'd0, logic [7:0] ra = 8'd0, bit err = 1'b0);
    console_cmd_t c;
    c.op                 = op;
    c.ch                 = ch;
    c.col                = col;
    c.row                = row;
    c.has_fixed          = has_fixed;
    c.fixed_res.cursor   = cur[10:0];
    c.fixed_res.scrolled = scr;
    c.fixed_res.rd_char  = rc;
    c.fixed_res.rd_attr  = ra;
    c.fixed_res.pos_err  = err;
    directed_cmds.push_back(c);
  endtask

  // Presents one word and holds it until taken; called and returns at a falling edge
  task automatic send_word(console_cmd_t c);
    console_result_t pred;
    if (tx_idle_pct > 0) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser  = c.op;
    in_tdata  = {4'd0, c.row, c.col, c.ch};
    do @(posedge clk); while (!in_tready);
    pred = predict_console(c.op, c.ch, c.col, c.row);
    pending_results.push_back(c.has_fixed ? c.fixed_res : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Attribute register write, only with the block idle
  task automatic write_attribute(logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    attr_shadow = value;
  endtask

  // Random command: mostly text at the cursor, with jumps, reads and the odd clear
  function automatic console_cmd_t random_word();
    console_cmd_t c;
    int           pick;
    int           chpick;
    pick   = $urandom_range(99);
    chpick = $urandom_range(99);
    if (pick < 1)
      c.op = OP_CLEAR;
    else if (pick < 15)
      c.op = OP_READ;
    else if (pick < 35)
      c.op = OP_PUT_AT;
    else
      c.op = OP_PUT_CUR;
    if (chpick < 5)
      c.ch = CH_NEWLINE;
    else if (chpick < 9)
      c.ch = CH_BACKSPACE;
    else
      c.ch = 8'($urandom_range(255));
    // one position in ten is drawn from the whole field range, so some miss the screen
    if ((c.op == OP_PUT_AT || c.op == OP_READ) && $urandom_range(9) != 0) begin
      c.col = 7'($urandom_range(COLUMNS - 1));
      c.row = 5'($urandom_range(ROWS - 1));
    end else begin
      c.col = 7'($urandom_range(127));
      c.row = 5'($urandom_range(31));
    end
    c.has_fixed = 1'b0;
    return c;
  endfunction

  initial begin
    int tx_pcts [4];
    int rx_pcts [4];
    logic [7:0] attrs [4];

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_PUT_CUR;
    in_tdata    = 24'd0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'd0;
    for (int i = 0; i < CELLS; i++)
      screen_shadow[i] = 16'd0;
    cursor_shadow = 0;
    attr_shadow   = DEFAULT_ATTR;

    // Directed table: fixed results where they are obvious, the rest predicted
    plan_word(OP_READ,     8'h00, 7'd0,   5'd0,  1, 0, 0, 8'h00, 8'h00, 0); // fresh screen
    plan_word(OP_PUT_CUR,  8'h41, 7'd0,   5'd0);
    plan_word(OP_READ,     8'h00, 7'd0,   5'd0);
    plan_word(OP_PUT_CUR,  CH_BACKSPACE, 7'd0, 5'd0);
    plan_word(OP_PUT_CUR,  CH_BACKSPACE, 7'd0, 5'd0, 1, 0); // sticks at cell zero
    plan_word(OP_PUT_AT,   8'h55, 7'd127, 5'd31, 1, 0, 0, 8'h00, 8'h00, 1);
    plan_word(OP_READ,     8'h00, 7'd80,  5'd0,  1, 0, 0, 8'h00, 8'h00, 1);
    plan_word(OP_READ,     8'h00, 7'd0,   5'd25, 1, 0, 0, 8'h00, 8'h00, 1);
    plan_word(OP_PUT_AT,   8'hFF, 7'd79,  5'd24); // last cell: scrolls
    plan_word(OP_READ,     8'h00, 7'd79,  5'd23); // moved up one row
    plan_word(OP_PUT_AT,   CH_NEWLINE, 7'd5, 5'd24); // newline on last row
    plan_word(OP_PUT_CUR,  CH_NEWLINE, 7'd0, 5'd0);
    plan_word(OP_READ,     8'h00, 7'd0,   5'd24); // zeroed last row
    plan_word(OP_PUT_AT,   8'h00, 7'd0,   5'd0);
    plan_word(OP_PUT_AT,   CH_BACKSPACE, 7'd0, 5'd0);
    plan_word(OP_PUT_AT,   CH_NEWLINE, 7'd40, 5'd3);
    plan_word(OP_READ,     8'h00, 7'd0,   5'd4);
    plan_word(OP_CLEAR,    8'hFF, 7'd127, 5'd31, 1, 0); // unused fields ignored
    plan_word(OP_READ,     8'hFF, 7'd79,  5'd24, 1, 0, 0, CH_SPACE, DEFAULT_ATTR, 0);
    plan_word(OP_PUT_CUR,  8'h7F, 7'd127, 5'd31);
    plan_word(OP_READ,     8'h00, 7'd127, 5'd0,  1, 1, 0, 8'h00, 8'h00, 1);
    plan_word(OP_READ,     8'h00, 7'd0,   5'd0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // block runs its zeroing pass first; in_tready holds the first word off
    foreach (directed_cmds[i])
      send_word(directed_cmds[i]);

    // Random phases: no idling, sender gaps, receiver stalls, both
    tx_pcts = '{0, 71, 0, 24};
    rx_pcts = '{0, 0, 71, 24};
    attrs   = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'($urandom_range(255))};
    for (int ph = 0; ph < 4; ph++) begin
      write_attribute(attrs[ph]);
      tx_idle_pct  = tx_pcts[ph];
      rx_stall_pct = rx_pcts[ph];
      repeat (PHASE_WORDS)
        send_word(random_word());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
